>>> hdl/rpa_pkg.sv
// Shared types and constants for the reference point association block.
// Holds the item payload structs, operation and register codes, and the
// command/status bundles passed between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

  // Table depth and count ceiling are tied to the payload field widths.
  localparam int NUM_REFS    = 64;
  localparam int MAX_MEMBERS = 1024;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_ASSOC = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] CFG_REF_COUNT   = 3'd0;
  localparam logic [2:0] CFG_INTERCEPT_0 = 3'd1;
  localparam logic [2:0] CFG_INTERCEPT_1 = 3'd2;
  localparam logic [2:0] CFG_INTERCEPT_2 = 3'd3;
  localparam logic [2:0] CFG_INTERCEPT_3 = 3'd4;

  // Divider dividend width covers obj << 16, the dot product and d1 * r.
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 32;
  localparam int SQ_W   = 64;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  ref_index;
    logic [15:0] ref_coord_0;
    logic [15:0] ref_coord_1;
    logic [15:0] ref_coord_2;
    logic [15:0] ref_coord_3;
    logic [31:0] obj_0;
    logic [31:0] obj_1;
    logic [31:0] obj_2;
    logic [31:0] obj_3;
    logic        sure_member;
  } rpa_in_t;

  typedef struct packed {
    logic [5:0]  nearest_ref;
    logic [31:0] distance;
    logic [10:0] niche_count;
    logic [10:0] sure_count;
  } rpa_out_t;

  typedef struct packed {
    logic [3:0][15:0] coord;
    logic [17:0]      norm;
  } rpa_entry_t;

  typedef struct packed {
    logic capture;
    logic clear_counts;
    logic sq_acc;
    logic sqrt_load;
    logic tbl_write;
    logic fdiv_start;
    logic f_store;
    logic tbl_read;
    logic ref_skip;
    logic dot_acc;
    logic d1_start;
    logic d1_store;
    logic pmul;
    logic pdiv_start;
    logic e_store;
    logic sq_mul;
    logic sum_acc;
    logic sqrt_dist;
    logic dist_store;
    logic cnt_read;
    logic cnt_update;
    logic out_load;
  } rpa_cmd_t;

  typedef struct packed {
    logic k_last;
    logic ref_end;
    logic norm_zero;
    logic div_done;
    logic sqrt_done;
    logic e_sat;
    logic sum_ovf;
  } rpa_stat_t;

endpackage

`default_nettype wire

>>> hdl/rpa_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for normalizing, projection and projected points.
`timescale 1ns / 1ps
`default_nettype none

module rpa_div #(
  parameter int NW = 56,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     rem_sh;
  logic [DW+1:0]   diff;

  assign rem_sh   = {rem_r, q_r[NW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DW+1]) begin
        rem_r <= diff[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpa_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Serves both the reference norm at load time and the final distance.
`timescale 1ns / 1ps
`default_nettype none

module rpa_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [rpa_pkg::SQ_W-1:0] radicand,
  output logic                      done,
  output logic [rpa_pkg::SQ_W/2-1:0] root
);

  import rpa_pkg::*;

  localparam int RW   = SQ_W / 2;
  localparam int CNTW = $clog2(RW + 1);

  logic [SQ_W-1:0] rad_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+2:0]   rem_t;
  logic [RW+2:0]   trial;

  assign rem_t = {rem_r[RW:0], rad_r[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[SQ_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= (RW+2)'(rem_t - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t[RW+1:0];
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpa_datapath.sv
// Datapath: configuration registers, reference table, count memories,
// arithmetic registers, the shared divider and square root. Uses rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_datapath #(
  parameter int NUM_OBJ = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rpa_pkg::rpa_in_t  in_data,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire rpa_pkg::rpa_cmd_t cmd,
  output rpa_pkg::rpa_stat_t     stat,
  output rpa_pkg::rpa_out_t      out_data
);

  import rpa_pkg::*;

  localparam int IW = $clog2(NUM_REFS);
  localparam int AW = $clog2(NUM_REFS + 1);
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  // configuration
  logic [6:0]  ref_count_r;
  logic [31:0] intercept_r [4];

  // item and working registers
  rpa_in_t     item_r;
  logic [1:0]  k_r;
  logic [33:0] sqacc_r;
  logic [31:0] f_r [4];
  logic [AW-1:0] ref_i_r;
  rpa_entry_t  rd_r;
  logic [50:0] dot_r;
  logic [39:0] d1_r;
  logic [55:0] prod_r;
  logic [31:0] e_r;
  logic        e_sat_r;
  logic [63:0] sq_r;
  logic [63:0] sum_r;
  logic        sat_r;
  logic        found_r;
  logic [IW-1:0] best_r;
  logic [31:0] best_d_r;
  rpa_out_t    res_r;
  rpa_out_t    out_r;

  // storage
  rpa_entry_t  tbl_mem [NUM_REFS];
  logic [CW-1:0] niche_mem [NUM_REFS];
  logic [CW-1:0] sure_mem [NUM_REFS];
  logic [NUM_REFS-1:0] cnt_vld_r;
  logic [CW-1:0] niche_rd_r;
  logic [CW-1:0] sure_rd_r;
  logic          vld_rd_r;

  // shared units
  logic          div_start;
  logic [55:0]   div_nd;
  logic [31:0]   div_dv;
  logic          div_done;
  logic [55:0]   div_q;
  logic          sqrt_start;
  logic [63:0]   sqrt_in;
  logic          sqrt_done;
  logic [31:0]   sqrt_root;

  // combinational helpers
  logic [15:0] in_coord [4];
  logic [31:0] obj [4];
  logic [15:0] tcoord;
  logic [31:0] f_cur;
  logic [31:0] ic_cur;
  logic [47:0] dot_term;
  logic [55:0] e_full;
  logic [64:0] sum_ext;
  logic [31:0] dist_val;
  logic        slot_ok;
  logic [IW-1:0] slot;
  logic [CW-1:0] niche_cur;
  logic [CW-1:0] sure_cur;
  logic [CW-1:0] niche_new;
  logic [CW-1:0] sure_new;

  assign in_coord[0] = item_r.ref_coord_0;
  assign in_coord[1] = item_r.ref_coord_1;
  assign in_coord[2] = item_r.ref_coord_2;
  assign in_coord[3] = item_r.ref_coord_3;
  assign obj[0]      = item_r.obj_0;
  assign obj[1]      = item_r.obj_1;
  assign obj[2]      = item_r.obj_2;
  assign obj[3]      = item_r.obj_3;

  assign tcoord   = rd_r.coord[k_r];
  assign f_cur    = f_r[k_r];
  assign ic_cur   = (intercept_r[k_r] == 32'd0) ? 32'd1 : intercept_r[k_r];
  assign dot_term = 48'(f_cur) * 48'(tcoord);
  assign e_full   = (div_q >= 56'(f_cur)) ? (div_q - 56'(f_cur)) : (56'(f_cur) - div_q);
  assign sum_ext  = {1'b0, sum_r} + {1'b0, sq_r};
  assign dist_val = sat_r ? '1 : sqrt_root;
  assign slot_ok  = 32'(item_r.ref_index) < NUM_REFS;
  assign slot     = IW'(item_r.ref_index);

  assign niche_cur = vld_rd_r ? niche_rd_r : '0;
  assign sure_cur  = vld_rd_r ? sure_rd_r : '0;
  assign niche_new = (found_r && 32'(niche_cur) < MAX_MEMBERS) ? niche_cur + 1'b1
                                                               : niche_cur;
  assign sure_new  = (found_r && item_r.sure_member && 32'(sure_cur) < MAX_MEMBERS)
                     ? sure_cur + 1'b1 : sure_cur;

  assign stat.k_last    = (k_r == 2'(NUM_OBJ - 1));
  assign stat.ref_end   = (32'(ref_i_r) >= 32'(ref_count_r)) || (32'(ref_i_r) >= NUM_REFS);
  assign stat.norm_zero = (rd_r.norm == 18'd0);
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.e_sat     = e_sat_r;
  assign stat.sum_ovf   = sum_ext[64];

  assign out_data = out_r;

  // divider operand select
  assign div_start = cmd.fdiv_start | cmd.d1_start | cmd.pdiv_start;
  always_comb begin
    priority if (cmd.fdiv_start) begin
      div_nd = 56'({obj[k_r], 16'h0000});
      div_dv = ic_cur;
    end else if (cmd.d1_start) begin
      div_nd = 56'(dot_r);
      div_dv = 32'(rd_r.norm);
    end else begin
      div_nd = prod_r;
      div_dv = 32'(rd_r.norm);
    end
  end

  assign sqrt_start = cmd.sqrt_load | cmd.sqrt_dist;
  assign sqrt_in    = cmd.sqrt_load ? 64'(sqacc_r) : sum_r;

  rpa_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_nd),
    .divisor  (div_dv),
    .done     (div_done),
    .quotient (div_q)
  );

  rpa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= 7'd1;
      for (int i = 0; i < 4; i++) begin
        intercept_r[i] <= 32'd65536;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REF_COUNT:   ref_count_r    <= cfg_data[6:0];
        CFG_INTERCEPT_0: intercept_r[0] <= cfg_data;
        CFG_INTERCEPT_1: intercept_r[1] <= cfg_data;
        CFG_INTERCEPT_2: intercept_r[2] <= cfg_data;
        CFG_INTERCEPT_3: intercept_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // count valid bits: a clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cmd.clear_counts) begin
      cnt_vld_r <= '0;
    end else if (cmd.cnt_update && found_r) begin
      cnt_vld_r[best_r] <= 1'b1;
    end
  end

  // reference table
  always_ff @(posedge clk) begin
    if (cmd.tbl_write && slot_ok) begin
      tbl_mem[slot] <= '{coord: {in_coord[3], in_coord[2], in_coord[1], in_coord[0]},
                         norm:  sqrt_root[17:0]};
    end
    if (cmd.tbl_read) begin
      rd_r <= tbl_mem[ref_i_r[IW-1:0]];
    end
  end

  // count memories
  always_ff @(posedge clk) begin
    if (cmd.cnt_update && found_r) begin
      niche_mem[best_r] <= niche_new;
      sure_mem[best_r]  <= sure_new;
    end
    if (cmd.cnt_read) begin
      niche_rd_r <= niche_mem[best_r];
      sure_rd_r  <= sure_mem[best_r];
      vld_rd_r   <= cnt_vld_r[best_r];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_data;
      sqacc_r  <= '0;
      ref_i_r  <= '0;
      found_r  <= 1'b0;
      best_r   <= '0;
      best_d_r <= '1;
      res_r    <= '0;
    end

    if (cmd.capture || cmd.tbl_read || cmd.dist_store) begin
      k_r <= '0;
    end else if (cmd.sq_acc || cmd.f_store || cmd.dot_acc || cmd.sum_acc) begin
      k_r <= stat.k_last ? 2'd0 : k_r + 1'b1;
    end

    if (cmd.sq_acc) begin
      sqacc_r <= sqacc_r + 34'(32'(in_coord[k_r]) * 32'(in_coord[k_r]));
    end

    if (cmd.f_store) begin
      f_r[k_r] <= (|div_q[55:32]) ? '1 : div_q[31:0];
    end

    if (cmd.tbl_read) begin
      dot_r <= '0;
      sum_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.e_store && (|e_full[55:32])) begin
        sat_r <= 1'b1;
      end
      if (cmd.sum_acc) begin
        if (sum_ext[64]) begin
          sat_r <= 1'b1;
        end else begin
          sum_r <= sum_ext[63:0];
        end
      end
      if (cmd.dot_acc) begin
        dot_r <= dot_r + 51'(dot_term);
      end
    end

    if (cmd.d1_store) begin
      d1_r <= (|div_q[55:40]) ? '1 : div_q[39:0];
    end

    if (cmd.pmul) begin
      prod_r <= 56'(d1_r) * 56'(tcoord);
    end

    if (cmd.e_store) begin
      e_sat_r <= |e_full[55:32];
      e_r     <= e_full[31:0];
    end

    if (cmd.sq_mul) begin
      sq_r <= 64'(e_r) * 64'(e_r);
    end

    if (cmd.ref_skip || cmd.dist_store) begin
      ref_i_r <= ref_i_r + 1'b1;
    end

    // strict compare keeps the lowest index on a tie
    if (cmd.dist_store && (!found_r || dist_val < best_d_r)) begin
      found_r  <= 1'b1;
      best_r   <= ref_i_r[IW-1:0];
      best_d_r <= dist_val;
    end

    if (cmd.cnt_update) begin
      res_r.nearest_ref <= 6'(best_r);
      res_r.distance    <= best_d_r;
      res_r.niche_count <= 11'(niche_new);
      res_r.sure_count  <= 11'(sure_new);
    end

    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpa_ctrl.sv
// Controller state machine: sequences load, clear, associate and no-op items
// through the datapath and owns the channel handshakes. Uses rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_op,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire rpa_pkg::rpa_stat_t stat,
  output rpa_pkg::rpa_cmd_t       cmd
);

  import rpa_pkg::*;

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_LD_SQ      = 5'd1;
  localparam logic [4:0] S_LD_SQRT    = 5'd2;
  localparam logic [4:0] S_LD_WAIT    = 5'd3;
  localparam logic [4:0] S_LD_WR      = 5'd4;
  localparam logic [4:0] S_F_START    = 5'd5;
  localparam logic [4:0] S_F_WAIT     = 5'd6;
  localparam logic [4:0] S_REF_CHK    = 5'd7;
  localparam logic [4:0] S_RD_WAIT    = 5'd8;
  localparam logic [4:0] S_DOT        = 5'd9;
  localparam logic [4:0] S_D1_START   = 5'd10;
  localparam logic [4:0] S_D1_WAIT    = 5'd11;
  localparam logic [4:0] S_P_MUL      = 5'd12;
  localparam logic [4:0] S_P_START    = 5'd13;
  localparam logic [4:0] S_P_WAIT     = 5'd14;
  localparam logic [4:0] S_E          = 5'd15;
  localparam logic [4:0] S_ACC        = 5'd16;
  localparam logic [4:0] S_DIST_START = 5'd17;
  localparam logic [4:0] S_DIST_WAIT  = 5'd18;
  localparam logic [4:0] S_CNT_RD     = 5'd19;
  localparam logic [4:0] S_CNT_UPD    = 5'd20;
  localparam logic [4:0] S_DONE       = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_op)
            OP_CLEAR: begin
              cmd.clear_counts = 1'b1;
              state_nxt        = S_DONE;
            end
            OP_LOAD:  state_nxt = S_LD_SQ;
            OP_ASSOC: state_nxt = S_F_START;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_LD_SQ: begin
        cmd.sq_acc = 1'b1;
        if (stat.k_last) begin
          state_nxt = S_LD_SQRT;
        end
      end
      S_LD_SQRT: begin
        cmd.sqrt_load = 1'b1;
        state_nxt     = S_LD_WAIT;
      end
      S_LD_WAIT: begin
        if (stat.sqrt_done) begin
          state_nxt = S_LD_WR;
        end
      end
      S_LD_WR: begin
        cmd.tbl_write = 1'b1;
        state_nxt     = S_DONE;
      end
      S_F_START: begin
        cmd.fdiv_start = 1'b1;
        state_nxt      = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (stat.div_done) begin
          cmd.f_store = 1'b1;
          state_nxt   = stat.k_last ? S_REF_CHK : S_F_START;
        end
      end
      S_REF_CHK: begin
        if (stat.ref_end) begin
          state_nxt = S_CNT_RD;
        end else begin
          cmd.tbl_read = 1'b1;
          state_nxt    = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        // skip directions with zero norm
        if (stat.norm_zero) begin
          cmd.ref_skip = 1'b1;
          state_nxt    = S_REF_CHK;
        end else begin
          state_nxt = S_DOT;
        end
      end
      S_DOT: begin
        cmd.dot_acc = 1'b1;
        if (stat.k_last) begin
          state_nxt = S_D1_START;
        end
      end
      S_D1_START: begin
        cmd.d1_start = 1'b1;
        state_nxt    = S_D1_WAIT;
      end
      S_D1_WAIT: begin
        if (stat.div_done) begin
          cmd.d1_store = 1'b1;
          state_nxt    = S_P_MUL;
        end
      end
      S_P_MUL: begin
        cmd.pmul  = 1'b1;
        state_nxt = S_P_START;
      end
      S_P_START: begin
        cmd.pdiv_start = 1'b1;
        state_nxt      = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (stat.div_done) begin
          cmd.e_store = 1'b1;
          state_nxt   = S_E;
        end
      end
      S_E: begin
        // an oversized residual saturates the distance; stop early
        if (stat.e_sat) begin
          state_nxt = S_DIST_START;
        end else begin
          cmd.sq_mul = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        cmd.sum_acc = 1'b1;
        if (stat.sum_ovf || stat.k_last) begin
          state_nxt = S_DIST_START;
        end else begin
          state_nxt = S_P_MUL;
        end
      end
      S_DIST_START: begin
        cmd.sqrt_dist = 1'b1;
        state_nxt     = S_DIST_WAIT;
      end
      S_DIST_WAIT: begin
        if (stat.sqrt_done) begin
          cmd.dist_store = 1'b1;
          state_nxt      = S_REF_CHK;
        end
      end
      S_CNT_RD: begin
        cmd.cnt_read = 1'b1;
        state_nxt    = S_CNT_UPD;
      end
      S_CNT_UPD: begin
        cmd.cnt_update = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/reference_point_association.sv
// Reference point association, one item at a time. A clear or no-op item
// goes straight to the hand-off; a load item takes the square root of the
// squared coordinates and writes it to the table as the reference norm. An
// associate item first normalizes the objectives, then handles each active
// nonzero-norm reference on the single bit-serial 56-bit divider (used for
// the projection and each projected coordinate) and the square root, and
// skips each zero-norm one; the final check, the count update and the
// hand-off follow. The result sits in an output register, so the next item
// is taken while it waits to be transferred. Configuration should be written
// through cfg_* (always ready) only while the block is idle; the block itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module reference_point_association #(
  parameter int NUM_OBJ = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rpa_pkg::rpa_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rpa_pkg::rpa_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  import rpa_pkg::*;

  rpa_cmd_t  cmd;
  rpa_stat_t stat;

  assign cfg_ready = 1'b1;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpa_datapath #(
    .NUM_OBJ (NUM_OBJ)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
